// ----- hw/rtl/ltc_pkg.sv -----
// ltc_pkg: beat payload types shared by the thumbnail tag cache
// no dependencies; used by lru_thumbnail_tag_cache

package ltc_pkg;

    // input beat payload
    typedef struct packed {
        logic [63:0] key;
        logic [9:0]  requested_size;
        logic [31:0] tick;
        logic        art_found;
    } in_t;

    // result beat payload
    typedef struct packed {
        logic       have_art;
        logic       hit;
        logic [3:0] slot;
        logic       flushed;
        logic       rejected;
    } out_t;

endpackage

// ----- hw/rtl/lru_thumbnail_tag_cache.sv -----
// lru_thumbnail_tag_cache: fully associative LRU tag store with negative caching
// depends on ltc_pkg (beat payload types)

// Fully associative tag cache of ENTRIES slots; every request beat yields exactly
// one result beat. Keys, loaded flags and last-use ticks sit in one synchronous
// memory with one read and one write port, and the empty flag of each slot in a
// flip-flop vector, so a size change flushes the whole cache by clearing that
// vector. A valid request walks the memory one slot per cycle, finding a hit, the
// first empty slot and the oldest slot in the same pass, then writes the chosen
// slot back; the walk goes through the one memory read port. A request with a zero
// key or zero size is rejected with no change to the cache. One request is in
// flight at a time; a new one is taken while the previous result beat still waits
// at the output register.
module lru_thumbnail_tag_cache #(
    parameter int ENTRIES   = 16,
    parameter int MAX_SIZE  = 128,
    parameter int KEY_BITS  = 64,
    parameter int TICK_BITS = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  ltc_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output ltc_pkg::out_t m_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int LU_W  = (TICK_BITS < 32) ? TICK_BITS : 32;
    localparam int MEM_W = KEY_BITS + 1 + LU_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]          state_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [ENTRIES-1:0]  valid_reg;
    logic [9:0]          size_reg;

    // request held for the walk
    logic [KEY_BITS-1:0] key_reg;
    logic [LU_W-1:0]     tick_reg;
    logic                art_reg;

    // walk trackers
    logic                hit_found_reg, empty_found_reg, min_found_reg;
    logic [IDX_W-1:0]    hit_idx_reg, empty_idx_reg, min_idx_reg;
    logic [LU_W-1:0]     min_lu_reg;
    logic                hit_art_reg;

    // memory read pipeline
    logic                cmp_ok_reg;
    logic [IDX_W-1:0]    cmp_idx_reg;
    logic [MEM_W-1:0]    rd_data_reg;

    ltc_pkg::out_t       pend_reg;
    ltc_pkg::out_t       out_reg;
    logic                m_valid_reg;

    logic [MEM_W-1:0]    mem [ENTRIES];

    // request decode
    logic                s_beat, reject;
    logic [9:0]          size_c;
    logic [KEY_BITS-1:0] key_in;
    assign s_beat = s_valid && s_ready;
    assign key_in = s_data.key[KEY_BITS-1:0];
    assign reject = (key_in == '0) || (s_data.requested_size == 10'd0);
    assign size_c = (s_data.requested_size > 10'(MAX_SIZE)) ? 10'(MAX_SIZE)
                                                           : s_data.requested_size;

    // memory port control
    logic                rd_en, wr_en;
    logic [IDX_W-1:0]    rd_addr, wr_addr;
    logic [MEM_W-1:0]    wr_data;
    assign rd_en   = (state_reg == S_SCAN) && (cnt_reg < CNT_W'(ENTRIES));
    assign rd_addr = cnt_reg[IDX_W-1:0];
    assign wr_en   = (state_reg == S_WRITE);
    assign wr_addr = hit_found_reg ? hit_idx_reg
                   : (empty_found_reg ? empty_idx_reg : min_idx_reg);
    assign wr_data = {key_reg, (hit_found_reg ? hit_art_reg : art_reg), tick_reg};

    // tag store memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // fields of the entry under comparison
    logic [KEY_BITS-1:0] d_key;
    logic                d_art;
    logic [LU_W-1:0]     d_lu;
    logic                d_valid;
    assign d_key   = rd_data_reg[MEM_W-1 -: KEY_BITS];
    assign d_art   = rd_data_reg[LU_W];
    assign d_lu    = rd_data_reg[LU_W-1:0];
    assign d_valid = valid_reg[cmp_idx_reg];

    // output register, loaded when the result beat slot is free
    logic out_free, out_load;
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (state_reg == S_DONE) && out_free;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // control: state, counter, valid bits, size
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            valid_reg   <= '0;
            size_reg    <= '0;
            cmp_ok_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            cmp_ok_reg <= rd_en;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_beat) begin
                        cnt_reg <= '0;
                        if (reject) begin
                            state_reg <= S_DONE;
                        end else begin
                            state_reg <= S_SCAN;
                            if (size_c != size_reg) begin
                                valid_reg <= '0;
                                size_reg  <= size_c;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(ENTRIES)) begin
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    valid_reg[wr_addr] <= 1'b1;
                    state_reg          <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath: request capture, walk trackers, result
    always_ff @(posedge aclk) begin
        cmp_idx_reg <= rd_addr;
        if (s_beat) begin
            key_reg         <= key_in;
            tick_reg        <= s_data.tick[LU_W-1:0];
            art_reg         <= s_data.art_found;
            hit_found_reg   <= 1'b0;
            empty_found_reg <= 1'b0;
            min_found_reg   <= 1'b0;
            // have_art, hit, slot, flushed, rejected
            pend_reg        <= ltc_pkg::out_t'({1'b0, 1'b0, 4'd0,
                                                !reject && (size_c != size_reg), reject});
        end
        // compare the entry read in the previous cycle
        if ((state_reg == S_SCAN) && cmp_ok_reg) begin
            if (!d_valid && !empty_found_reg) begin
                empty_found_reg <= 1'b1;
                empty_idx_reg   <= cmp_idx_reg;
            end
            if (d_valid && !hit_found_reg && (d_key == key_reg)) begin
                hit_found_reg <= 1'b1;
                hit_idx_reg   <= cmp_idx_reg;
                hit_art_reg   <= d_art;
            end
            if (d_valid && (!min_found_reg || (d_lu < min_lu_reg))) begin
                min_found_reg <= 1'b1;
                min_lu_reg    <= d_lu;
                min_idx_reg   <= cmp_idx_reg;
            end
        end
        if (state_reg == S_WRITE) begin
            pend_reg <= ltc_pkg::out_t'({(hit_found_reg ? hit_art_reg : art_reg),
                                         hit_found_reg, 4'(wr_addr),
                                         pend_reg.flushed, pend_reg.rejected});
        end
        if (out_load) begin
            out_reg <= pend_reg;
        end
    end

    // a rejected request leaves the cache untouched
    a_reject_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_beat && reject) |=> ($stable(valid_reg) && $stable(size_reg)))
        else $error("rejected request changed cache state");

    // a hit is only ever taken on an occupied slot
    a_hit_occupied: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WRITE && hit_found_reg) |-> valid_reg[hit_idx_reg])
        else $error("hit on an empty slot");

    // at write-back with no empty slot, the oldest slot has been found
    a_victim_known: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WRITE && !hit_found_reg && !empty_found_reg) |-> min_found_reg)
        else $error("no victim chosen");

    // a pending result beat is never overwritten
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result beat dropped or changed");

endmodule
